@@ rtl/vpd_pkg.sv @@
`timescale 1ns / 1ps
package vpd_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned IdxW = 3;
  localparam int unsigned DataW = 64;
  localparam int unsigned QW = 48;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_WZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic [1:0] status;
  } out_item_t;

  // transformed vertex handed from front to back
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] tw;
    logic sat;
  } xf_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -66'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > 66'sh7FFFFFFF) || (v < -66'sh80000000);
  endfunction

endpackage

@@ rtl/vpd_fifo.sv @@
`timescale 1ns / 1ps
module vpd_fifo #(
  parameter int unsigned W = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int unsigned AW = $clog2(DEPTH);
  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic do_wr, do_rd;

  assign full = (cnt == (AW+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wdata;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end
endmodule

@@ rtl/vpd_front.sv @@
`timescale 1ns / 1ps
// Matrix multiply: stage 1 products, stage 2 row sums with round and saturate.
module vpd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [vpd_pkg::DataW-1:0]  regs [vpd_pkg::NumRegs],
  input  logic                       in_valid,
  input  vpd_pkg::in_item_t          in_item,
  input  logic                       advance,
  output logic                       s1_valid,
  output logic                       out_valid,
  output vpd_pkg::xf_item_t          out_item
);
  logic signed [63:0] prod [4][4];
  logic signed [65:0] sum [4];
  logic signed [65:0] rnd [4];
  logic signed [31:0] v [4];
  logic signed [31:0] t [4];
  logic sat_any;

  assign v[0] = in_item.in_x;
  assign v[1] = in_item.in_y;
  assign v[2] = in_item.in_z;
  assign v[3] = in_item.in_w;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= $signed(regs[i*2 + j/2][(j%2)*32 +: 32]) * v[j];
        end
      end
    end
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      out_valid <= s1_valid;
    end
  end

  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < 4; i++) begin
      sum[i] = 66'(prod[i][0]) + 66'(prod[i][1]) + 66'(prod[i][2]) + 66'(prod[i][3])
               + 66'sd32768;
      rnd[i] = sum[i] >>> 16;
      t[i] = vpd_pkg::sat32(rnd[i]);
      sat_any = sat_any | vpd_pkg::ovf32(rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.tx <= t[0];
      out_item.ty <= t[1];
      out_item.tz <= t[2];
      out_item.tw <= t[3];
      out_item.sat <= sat_any;
    end
  end
endmodule

@@ rtl/vpd_back.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, three lanes.
module vpd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  vpd_pkg::xf_item_t in_item,
  input  logic              advance,
  output logic              out_valid,
  output vpd_pkg::out_item_t out_item
);
  localparam int unsigned N = vpd_pkg::QW;
  localparam int unsigned S = N + 1;

  typedef struct packed {
    logic [2:0][N-1:0] num;
    logic [2:0][N-1:0] rem;
    logic [2:0]        neg;
    logic [2:0][1:0]   sgn;
    logic [31:0]       den;
    logic signed [31:0] tw;
    logic              sat;
    logic              wz;
  } lane_t;

  lane_t st [S];
  logic vld [S];
  lane_t ld;
  logic signed [31:0] tin [3];
  logic [31:0] aden;

  assign tin[0] = in_item.tx;
  assign tin[1] = in_item.ty;
  assign tin[2] = in_item.tz;
  assign aden = in_item.tw[31] ? 32'(-in_item.tw) : 32'(in_item.tw);

  always_comb begin
    logic [N-1:0] a;
    ld = '0;
    for (int i = 0; i < 3; i++) begin
      a = tin[i][31] ? N'(-{{16{tin[i][31]}}, tin[i], 16'h0})
                     : N'({tin[i], 16'h0});
      ld.num[i] = a;
      ld.neg[i] = tin[i][31] ^ in_item.tw[31];
      ld.sgn[i] = tin[i][31] ? 2'b10 : ((tin[i] != 0) ? 2'b01 : 2'b00);
    end
    ld.den = aden;
    ld.tw = in_item.tw;
    ld.sat = in_item.sat;
    ld.wz = (in_item.tw == 0);
  end

  always_ff @(posedge clk) begin
    lane_t nx;
    logic [N:0] r;
    if (advance) begin
      st[0] <= ld;
      for (int k = 1; k < S; k++) begin
        nx = st[k-1];
        for (int i = 0; i < 3; i++) begin
          r = {st[k-1].rem[i], st[k-1].num[i][N-1]};
          if (r >= (N+1)'(st[k-1].den)) begin
            nx.rem[i] = N'(r - (N+1)'(st[k-1].den));
            nx.num[i] = {st[k-1].num[i][N-2:0], 1'b1};
          end else begin
            nx.rem[i] = N'(r);
            nx.num[i] = {st[k-1].num[i][N-2:0], 1'b0};
          end
        end
        st[k] <= nx;
      end
    end
    if (rst) begin
      for (int k = 0; k < S; k++) vld[k] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int k = 1; k < S; k++) vld[k] <= vld[k-1];
    end
  end

  logic signed [31:0] q [3];
  logic qsat;
  always_comb begin
    logic signed [N:0] sq;
    qsat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sq = st[S-1].neg[i] ? -$signed({1'b0, st[S-1].num[i]})
                          : $signed({1'b0, st[S-1].num[i]});
      if (st[S-1].wz) begin
        q[i] = st[S-1].sgn[i][1] ? 32'sh80000000
             : (st[S-1].sgn[i][0] ? 32'sh7FFFFFFF : 32'sh0);
      end else begin
        q[i] = vpd_pkg::sat32(66'(sq));
        qsat = qsat | vpd_pkg::ovf32(66'(sq));
      end
    end
  end

  assign out_valid = vld[S-1];
  always_comb begin
    out_item.out_x = q[0];
    out_item.out_y = q[1];
    out_item.out_z = q[2];
    out_item.out_w = st[S-1].tw;
    if (st[S-1].wz) out_item.status = vpd_pkg::STATUS_WZERO;
    else if (st[S-1].sat || qsat) out_item.status = vpd_pkg::STATUS_SAT;
    else out_item.status = vpd_pkg::STATUS_OK;
  end
endmodule

@@ rtl/vertex_project_perspective_divide.sv @@
`timescale 1ns / 1ps
// Path from an accepted item to its result on the outputs: input queue,
// matrix multiply, mid queue, 48 divide stages after the divider load, result queue.
// Throughput: one vertex per cycle; each pipe advances whenever its last stage is empty
// or its downstream queue has room, so a stalled receiver backs the block up to full.
// Reset (rst, synchronous): matrix returns to its reset values, all queues and pipes empty.
module vertex_project_perspective_divide #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  vpd_pkg::in_item_t             in_item,
  output logic                          full,
  input  logic                          pop,
  output vpd_pkg::out_item_t            out_item,
  output logic                          empty,
  input  logic                          cfg_we,
  input  logic [vpd_pkg::IdxW-1:0]      cfg_idx,
  input  logic [vpd_pkg::DataW-1:0]     cfg_data
);
  // matrix registers
  logic [vpd_pkg::DataW-1:0] regs [vpd_pkg::NumRegs];
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'h0000000100000000;
      regs[1] <= 64'h0;
      regs[2] <= 64'h0001000000000000;
      regs[3] <= 64'h0;
      regs[4] <= 64'h0;
      regs[5] <= 64'h0000000000010000;
      regs[6] <= 64'h0;
      regs[7] <= 64'h0001000000000000;
    end else if (cfg_we) begin
      regs[cfg_idx] <= cfg_data;
    end
  end

  // front: input queue feeds the multiply pipe, which stalls only when its last stage
  // holds an item the mid queue cannot take
  logic iq_empty, iq_pop;
  vpd_pkg::in_item_t iq_data;
  vpd_fifo #(.W($bits(vpd_pkg::in_item_t)), .DEPTH(QDEPTH)) u_iq (
    .clk, .rst, .wr(push), .wdata(in_item), .full(full),
    .rd(iq_pop), .rdata(iq_data), .empty(iq_empty)
  );

  logic f_adv, f_s1, f_vld, mq_full, mq_empty, mq_pop;
  vpd_pkg::xf_item_t f_item, mq_data;

  // mid queue deep enough for the two front stages plus slack
  vpd_fifo #(.W($bits(vpd_pkg::xf_item_t)), .DEPTH(4)) u_mq (
    .clk, .rst, .wr(f_vld && f_adv), .wdata(f_item), .full(mq_full),
    .rd(mq_pop), .rdata(mq_data), .empty(mq_empty)
  );

  // advance the front when its output stage can drain into the queue
  assign f_adv = !f_vld || !mq_full;
  assign iq_pop = f_adv && !iq_empty;

  vpd_front u_front (
    .clk, .rst, .regs, .in_valid(!iq_empty), .in_item(iq_data),
    .advance(f_adv), .s1_valid(f_s1), .out_valid(f_vld), .out_item(f_item)
  );

  // back: divide pipe advances unless its last stage holds an item the full
  // result queue cannot take; hold everything in place while stalled
  logic b_vld, oq_full, b_in, b_adv;
  vpd_pkg::out_item_t b_item;

  assign b_adv = !b_vld || !oq_full;
  assign b_in = !mq_empty && b_adv;
  assign mq_pop = b_in;

  vpd_back u_back (
    .clk, .rst, .in_valid(b_in), .in_item(mq_data), .advance(b_adv),
    .out_valid(b_vld), .out_item(b_item)
  );

  vpd_fifo #(.W($bits(vpd_pkg::out_item_t)), .DEPTH(QDEPTH)) u_oq (
    .clk, .rst, .wr(b_vld), .wdata(b_item), .full(oq_full),
    .rd(pop), .rdata(out_item), .empty(empty)
  );

  logic unused;
  assign unused = f_s1;
endmodule
